@@ sv/tws_pkg.sv @@
// shared constants, types and angle table of the trig waveshaper
package tws_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned GAIN_W     = 16;

  localparam logic REG_DRIVE_GAIN = 1'b0;
  localparam logic REG_SHAPE      = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

  typedef enum logic {
    SHAPE_SINE = 1'b0,
    SHAPE_ATAN = 1'b1
  } shape_e;

  // input aligned to q1.31, product with the gain in half-turns at 2^45
  localparam int unsigned ALIGN_W        = 32;
  localparam int unsigned PHASE_W        = 48;
  localparam int unsigned HALF_TURN_BITS = 45;
  localparam int unsigned MAG_SHIFT      = 15;
  localparam int unsigned MAG_W          = PHASE_W - MAG_SHIFT;

  localparam logic signed [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << HALF_TURN_BITS;
  localparam logic signed [PHASE_W-1:0] PHASE_HALF = PHASE_W'(1) << (HALF_TURN_BITS - 1);

  // pi in q2.29, product rounded back to q30 radians
  localparam int unsigned PI_W     = 31;
  localparam logic [PI_W-1:0] PI_Q29 = 31'd1686629713;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned PI_FRAC  = 29;
  localparam int unsigned RAD_W    = PROD_W - PI_FRAC;
  localparam logic [PROD_W-1:0] PI_ROUND = PROD_W'(1) << (PI_FRAC - 1);

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CORDIC_W     = 38;
  localparam int unsigned ANGLE_W      = 34;
  localparam int unsigned STEP_ANGLE_W = 30;

  localparam logic signed [CORDIC_W-1:0] CORDIC_K   = 38'sd652032874;
  localparam logic signed [CORDIC_W-1:0] CORDIC_ONE = 38'sd1073741824;

  typedef struct packed {
    shape_e                      mode;
    logic signed [CORDIC_W-1:0]  x;
    logic signed [CORDIC_W-1:0]  y;
    logic signed [ANGLE_W-1:0]   z;
  } cordic_t;

  // atan(2^-i) in q30, truncated
  function automatic logic [STEP_ANGLE_W-1:0] step_angle(input int unsigned i);
    logic [STEP_ANGLE_W-1:0] a;
    case (i)
      0:  a = 30'd843314856;
      1:  a = 30'd497837829;
      2:  a = 30'd263043836;
      3:  a = 30'd133525158;
      4:  a = 30'd67021686;
      5:  a = 30'd33543515;
      6:  a = 30'd16775850;
      7:  a = 30'd8388437;
      8:  a = 30'd4194282;
      9:  a = 30'd2097149;
      10: a = 30'd1048575;
      11: a = 30'd524287;
      12: a = 30'd262143;
      13: a = 30'd131071;
      14: a = 30'd65535;
      15: a = 30'd32767;
      16: a = 30'd16383;
      17: a = 30'd8191;
      18: a = 30'd4095;
      19: a = 30'd2047;
      20: a = 30'd1023;
      21: a = 30'd511;
      22: a = 30'd255;
      23: a = 30'd127;
      24: a = 30'd63;
      25: a = 30'd31;
      26: a = 30'd15;
      27: a = 30'd8;
      28: a = 30'd4;
      29: a = 30'd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ sv/tws_stream_if.sv @@
// valid/ready sample channels of the trig waveshaper
interface tws_in_if #(
  parameter int unsigned SAMPLE_BITS = tws_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface tws_out_if #(
  parameter int unsigned SAMPLE_BITS = tws_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

@@ sv/tws_cordic.sv @@
// unrolled cordic pipeline, one iteration per register stage, rotation or vectoring
module tws_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  tws_pkg::cordic_t init_i,
  output logic             valid_o,
  output tws_pkg::cordic_t res_o
);
  import tws_pkg::*;

  logic    valid_q [CORDIC_STEPS+1];
  cordic_t stage_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= init_i;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [ANGLE_W-1:0]  ang;
    logic                       pos;
    cordic_t                    nxt;

    assign dx  = stage_q[k].y >>> k;
    assign dy  = stage_q[k].x >>> k;
    assign ang = signed'(ANGLE_W'(step_angle(k)));
    // rotation steers on the residual angle, vectoring on the sign of y
    assign pos = (stage_q[k].mode == SHAPE_ATAN) ? stage_q[k].y[CORDIC_W-1]
                                                 : ~stage_q[k].z[ANGLE_W-1];

    always_comb begin
      nxt.mode = stage_q[k].mode;
      if (pos) begin
        nxt.x = stage_q[k].x - dx;
        nxt.y = stage_q[k].y + dy;
        nxt.z = stage_q[k].z - ang;
      end else begin
        nxt.x = stage_q[k].x + dx;
        nxt.y = stage_q[k].y - dy;
        nxt.z = stage_q[k].z + ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k+1] <= nxt;
      end
    end
  end

  assign valid_o = valid_q[CORDIC_STEPS];
  assign res_o   = stage_q[CORDIC_STEPS];

endmodule

@@ sv/trig_waveshaper_top.sv @@
// trig waveshaper top: apb registers, phase front end, cordic pipeline, output buffer
// an accepted input beat is registered in stages 1 to 5, the cordic and the output register
// throughput: one beat per cycle while the skid entry is empty; the 30-stage cordic is unrolled
// in_i.ready drops only while the output skid entry is full, so stalls lose and repeat nothing
// reset: async active low, clears all valid bits, drive_gain to 1.0, shape_select to sine
module trig_waveshaper_top #(
  parameter int unsigned SAMPLE_BITS = tws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tws_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tws_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tws_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  tws_in_if.sink                         in_i,
  tws_out_if.source                      out_o
);
  import tws_pkg::*;

  localparam int unsigned SHIFT = ALIGN_W - SAMPLE_BITS;
  localparam int unsigned VW    = CORDIC_W + 1;
  localparam logic signed [VW-1:0] OUT_MAX = VW'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [VW-1:0] OUT_MIN = VW'(-(longint'(1) <<< (SAMPLE_BITS - 1)));

  // configuration registers
  logic [GAIN_W-1:0] drive_gain_q;
  shape_e            shape_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_gain_q <= GAIN_RESET;
      shape_q      <= SHAPE_SINE;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DRIVE_GAIN: drive_gain_q <= pwdata[GAIN_W-1:0];
        REG_SHAPE:      shape_q      <= shape_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DRIVE_GAIN: prdata = APB_DATA_W'(drive_gain_q);
      REG_SHAPE:      prdata = APB_DATA_W'(shape_q);
      default:        prdata = '0;
    endcase
  end

  // pipeline advance, held only by a full skid entry
  logic adv;
  logic skid_valid_q;
  assign adv        = ~skid_valid_q;
  assign in_i.ready = adv;

  // stage 1: align and multiply by the drive gain
  logic signed [ALIGN_W-1:0] x_align;
  logic signed [PHASE_W-1:0] phase_d;
  logic                      s1_valid_q;
  shape_e                    s1_mode_q;
  logic signed [PHASE_W-1:0] s1_phase_q;

  assign x_align = ALIGN_W'(in_i.sample_in) <<< SHIFT;
  assign phase_d = x_align * signed'({1'b0, drive_gain_q});

  // stage 2: fold into [-0.5, 0.5] half-turns for sine
  logic signed [PHASE_W-1:0] wrap;
  logic signed [PHASE_W-1:0] fold;
  logic                      s2_valid_q;
  shape_e                    s2_mode_q;
  logic signed [PHASE_W-1:0] s2_arg_q;

  assign wrap = PHASE_W'(signed'(s1_phase_q[HALF_TURN_BITS:0]));

  always_comb begin
    if (wrap > PHASE_HALF) begin
      fold = PHASE_ONE - wrap;
    end else if (wrap < -PHASE_HALF) begin
      fold = -PHASE_ONE - wrap;
    end else begin
      fold = wrap;
    end
  end

  // stage 3: magnitude, truncated to 2^30 half-turn scale
  logic [PHASE_W-1:0] arg_mag;
  logic               s3_valid_q;
  shape_e             s3_mode_q;
  logic               s3_neg_q;
  logic [MAG_W-1:0]   s3_mag_q;

  assign arg_mag = s2_arg_q[PHASE_W-1] ? PHASE_W'(-s2_arg_q) : PHASE_W'(s2_arg_q);

  // stage 4: times pi
  logic              s4_valid_q;
  shape_e            s4_mode_q;
  logic              s4_neg_q;
  logic [PROD_W-1:0] s4_prod_q;

  // stage 5: round to q30 radians
  logic [PROD_W-1:0] prod_rnd;
  logic              s5_valid_q;
  shape_e            s5_mode_q;
  logic              s5_neg_q;
  logic [RAD_W-1:0]  s5_rad_q;

  assign prod_rnd = s4_prod_q + PI_ROUND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mode_q  <= shape_q;
      s1_phase_q <= phase_d;
      s2_mode_q  <= s1_mode_q;
      s2_arg_q   <= (s1_mode_q == SHAPE_ATAN) ? s1_phase_q : fold;
      s3_mode_q  <= s2_mode_q;
      s3_neg_q   <= s2_arg_q[PHASE_W-1];
      s3_mag_q   <= arg_mag[PHASE_W-1:MAG_SHIFT];
      s4_mode_q  <= s3_mode_q;
      s4_neg_q   <= s3_neg_q;
      s4_prod_q  <= PROD_W'(s3_mag_q) * PROD_W'(PI_Q29);
      s5_mode_q  <= s4_mode_q;
      s5_neg_q   <= s4_neg_q;
      s5_rad_q   <= prod_rnd[PROD_W-1:PI_FRAC];
    end
  end

  // signed angle and cordic start vector
  logic signed [RAD_W:0] theta;
  cordic_t               cordic_init;

  assign theta = s5_neg_q ? -signed'({1'b0, s5_rad_q}) : signed'({1'b0, s5_rad_q});

  always_comb begin
    cordic_init.mode = s5_mode_q;
    if (s5_mode_q == SHAPE_ATAN) begin
      cordic_init.x = CORDIC_ONE;
      cordic_init.y = CORDIC_W'(theta);
      cordic_init.z = '0;
    end else begin
      cordic_init.x = CORDIC_K;
      cordic_init.y = '0;
      cordic_init.z = ANGLE_W'(theta);
    end
  end

  logic    tail_valid;
  cordic_t tail;

  tws_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s5_valid_q),
    .init_i  (cordic_init),
    .valid_o (tail_valid),
    .res_o   (tail)
  );

  // round to the output format and saturate
  logic signed [CORDIC_W-1:0]    tail_v;
  logic signed [VW-1:0]          v_ext;
  logic signed [VW-1:0]          v_rnd;
  logic signed [SAMPLE_BITS-1:0] res_d;

  assign tail_v = (tail.mode == SHAPE_ATAN) ? CORDIC_W'(tail.z) : tail.y;
  assign v_ext  = VW'(tail_v);

  if (SHIFT > 0) begin : g_round
    localparam logic signed [VW-1:0] RND = VW'(longint'(1) << (SHIFT - 1));
    assign v_rnd = (v_ext + RND) >>> SHIFT;
  end else begin : g_no_round
    assign v_rnd = v_ext;
  end

  always_comb begin
    if (v_rnd > OUT_MAX) begin
      res_d = SAMPLE_BITS'(OUT_MAX);
    end else if (v_rnd < OUT_MIN) begin
      res_d = SAMPLE_BITS'(OUT_MIN);
    end else begin
      res_d = SAMPLE_BITS'(v_rnd);
    end
  end

  // output register with one skid entry behind it
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_data_q;
  logic signed [SAMPLE_BITS-1:0] skid_data_q;
  logic                          out_free;

  assign out_free = ~out_valid_q | out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= tail_valid;
      end
    end else if (tail_valid && adv) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : res_d;
    end else if (adv) begin
      skid_data_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  // checks
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a beat while the output register is empty");

  a_tail_parked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_valid && adv && out_valid_q && !out_o.ready) |=> skid_valid_q)
    else $error("pipeline tail beat dropped while output stalled");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("accepted input beat missing from first stage");

endmodule
